### hw/rtl/rpxy_pkg.sv
// Shared constants, types and state codes of the radial profile to XY core.
// No dependencies; every other file in hw/rtl but rpxy_ram uses it by scoped names.
package rpxy_pkg;

  localparam int MAX_RADIUS  = 256;
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 12;
  localparam int COORD_BITS  = 8;

  localparam int ADDR_BITS  = $clog2(MAX_RADIUS);
  localparam int COUNT_BITS = 9;

  // x*x + y*y, padded to an even width so the root takes it a pair at a time
  localparam int SUMSQ_BITS = 2 * COORD_BITS + 1;
  localparam int SQ_PAIRS   = (SUMSQ_BITS + 1) / 2;
  localparam int SQ_BITS    = 2 * SQ_PAIRS;

  localparam int ROOT_STEPS = SQ_PAIRS + FRAC_BITS;
  localparam int ROOT_BITS  = ROOT_STEPS;
  localparam int REM_BITS   = ROOT_BITS + 2;
  localparam int INDEX_BITS = ROOT_BITS - FRAC_BITS;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int ACC_BITS  = SAMPLE_BITS + 2;

  localparam int SQ_STEPS  = COORD_BITS;
  localparam int MUL_STEPS = FRAC_BITS;
  localparam int STEP_BITS = $clog2(ROOT_STEPS);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_RADIUS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_CHECK,
    ST_READ0,
    ST_READ1,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sq_step;
    logic rt_step;
  } radius_ctl_t;

  typedef struct packed {
    logic load_base;
    logic load_diff;
    logic step;
  } interp_ctl_t;

endpackage

### hw/rtl/rpxy_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rpxy_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/rpxy_radius.sv
// Pixel radius unit: bit-serial sum of squares, then a restoring square root
// that retires one root bit per step. Depends on rpxy_pkg.
module rpxy_radius (
  input  logic                             clk,
  input  rpxy_pkg::radius_ctl_t            ctl,
  input  logic [rpxy_pkg::COORD_BITS-1:0]  pixel_x,
  input  logic [rpxy_pkg::COORD_BITS-1:0]  pixel_y,
  output logic [rpxy_pkg::ROOT_BITS-1:0]   root
);

  logic [rpxy_pkg::SUMSQ_BITS-1:0] x_mult, y_mult;
  logic [rpxy_pkg::COORD_BITS-1:0] x_bits, y_bits;
  logic [rpxy_pkg::SQ_BITS-1:0]    sq;
  logic [rpxy_pkg::REM_BITS-1:0]   rem;
  logic [rpxy_pkg::ROOT_BITS-1:0]  root_q;

  logic [rpxy_pkg::SUMSQ_BITS-1:0] x_part, y_part, sq_sum;
  logic [rpxy_pkg::REM_BITS-1:0]   rem_sh, trial;
  logic                            fits;

  always_comb begin
    x_part = x_bits[0] ? x_mult : '0;
    y_part = y_bits[0] ? y_mult : '0;
    sq_sum = sq[rpxy_pkg::SUMSQ_BITS-1:0] + x_part + y_part;
    // bring down the next pair of the radicand; the low bits are the
    // fraction zeros shifted in behind it
    rem_sh = {rem[rpxy_pkg::REM_BITS-3:0], sq[rpxy_pkg::SQ_BITS-1 -: 2]};
    trial  = {root_q, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_mult <= rpxy_pkg::SUMSQ_BITS'(pixel_x);
      y_mult <= rpxy_pkg::SUMSQ_BITS'(pixel_y);
      x_bits <= pixel_x;
      y_bits <= pixel_y;
      sq     <= '0;
      rem    <= '0;
      root_q <= '0;
    end else if (ctl.sq_step) begin
      x_mult <= {x_mult[rpxy_pkg::SUMSQ_BITS-2:0], 1'b0};
      y_mult <= {y_mult[rpxy_pkg::SUMSQ_BITS-2:0], 1'b0};
      x_bits <= {1'b0, x_bits[rpxy_pkg::COORD_BITS-1:1]};
      y_bits <= {1'b0, y_bits[rpxy_pkg::COORD_BITS-1:1]};
      sq     <= rpxy_pkg::SQ_BITS'(sq_sum);
    end else if (ctl.rt_step) begin
      sq <= {sq[rpxy_pkg::SQ_BITS-3:0], 2'b00};
      if (fits) begin
        rem    <= rem_sh - trial;
        root_q <= {root_q[rpxy_pkg::ROOT_BITS-2:0], 1'b1};
      end else begin
        rem    <= rem_sh;
        root_q <= {root_q[rpxy_pkg::ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  assign root = root_q;

endmodule

### hw/rtl/rpxy_interp.sv
// Interpolation unit: serial fraction-times-difference multiply, one fraction
// bit per step, LSB first, with a floor shift each step. Depends on rpxy_pkg.
module rpxy_interp (
  input  logic                                    clk,
  input  rpxy_pkg::interp_ctl_t                   ctl,
  input  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] sample,
  input  logic        [rpxy_pkg::FRAC_BITS-1:0]   frac,
  output logic signed [rpxy_pkg::SAMPLE_BITS-1:0] value
);

  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] base;
  logic signed [rpxy_pkg::DIFF_BITS-1:0]   diff;
  logic        [rpxy_pkg::FRAC_BITS-1:0]   f_bits;
  logic signed [rpxy_pkg::ACC_BITS-1:0]    acc;

  logic signed [rpxy_pkg::ACC_BITS-1:0] acc_sum;

  // floor((floor(a/2) + b) / 2) == floor((a + 2b) / 4): per-step arithmetic
  // shifts give the floor of the whole product over 2^FRAC_BITS
  always_comb begin
    acc_sum = acc + (f_bits[0] ? rpxy_pkg::ACC_BITS'(diff) : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load_base) begin
      base <= sample;
      acc  <= '0;
    end else if (ctl.load_diff) begin
      diff   <= rpxy_pkg::DIFF_BITS'(sample) - rpxy_pkg::DIFF_BITS'(base);
      f_bits <= frac;
    end else if (ctl.step) begin
      acc    <= acc_sum >>> 1;
      f_bits <= {1'b0, f_bits[rpxy_pkg::FRAC_BITS-1:1]};
    end
  end

  assign value = base + acc[rpxy_pkg::SAMPLE_BITS-1:0];

endmodule

### hw/rtl/radial_profile_to_xy_core.sv
// Top level of the radial profile to XY core: sequencer, sample store,
// radius unit and interpolation unit. Depends on rpxy_pkg, rpxy_ram,
// rpxy_radius and rpxy_interp.
//
//  channel   | signals                                         | transfer when
//  ----------+-------------------------------------------------+------------------------
//  command   | start, busy, cmd, sample_index, sample_value,   | start & !busy
//            | pixel_x, pixel_y                                |
//  result    | result_valid, pixel_value, outside              | result_valid (1 cycle)
//  config    | cfg_valid, cfg_ready, cfg_data (radius_count)   | cfg_valid & cfg_ready
//
// A write command is stored at the transfer edge and busy stays low. A query
// holds busy for 8 sum-of-squares steps and 21 square root steps, one root
// bit per cycle; the result strobe then follows the radius check when the
// radius is outside the profile, one store read when one sample is returned
// as it is, and two store reads plus a 12-step serial multiply when the two
// samples are interpolated. A new command may be taken in the cycle of the result strobe.
// Reset (rst, synchronous) returns the sequencer to idle and radius_count to
// 256; the sample store is not cleared. The receiver cannot stall results.
module radial_profile_to_xy_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // command channel
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    cmd,
  input  logic        [7:0]                       sample_index,
  input  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic        [rpxy_pkg::COORD_BITS-1:0]  pixel_x,
  input  logic        [rpxy_pkg::COORD_BITS-1:0]  pixel_y,
  // configuration channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic        [rpxy_pkg::COUNT_BITS-1:0]  cfg_data,
  // result channel
  output logic                                    result_valid,
  output logic signed [rpxy_pkg::SAMPLE_BITS-1:0] pixel_value,
  output logic                                    outside
);

  rpxy_pkg::state_t state, state_next;

  logic [rpxy_pkg::STEP_BITS-1:0]  cnt, cnt_next;
  logic [rpxy_pkg::COUNT_BITS-1:0] radius_count;

  logic                                    result_valid_next;
  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] pixel_value_next;
  logic                                    outside_next;

  rpxy_pkg::radius_ctl_t radius_ctl;
  rpxy_pkg::interp_ctl_t interp_ctl;

  logic [rpxy_pkg::ROOT_BITS-1:0]  root;
  logic [rpxy_pkg::INDEX_BITS-1:0] ri;
  logic [rpxy_pkg::FRAC_BITS-1:0]  frac;
  logic [rpxy_pkg::COUNT_BITS-1:0] count_eff;
  logic                            ri_outside;
  logic                            use_next;

  logic                                    accept;
  logic                                    ram_we, ram_re;
  logic [rpxy_pkg::ADDR_BITS-1:0]          ram_raddr;
  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] ram_rdata;
  logic signed [rpxy_pkg::SAMPLE_BITS-1:0] interp_value;

  assign busy      = (state != rpxy_pkg::ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // Store samples straight from the command port; writes never wait.
  assign ram_we = accept && (cmd == rpxy_pkg::CMD_WRITE);

  // Split the root into sample index and fraction; clamp the count.
  assign ri        = root[rpxy_pkg::ROOT_BITS-1:rpxy_pkg::FRAC_BITS];
  assign frac      = root[rpxy_pkg::FRAC_BITS-1:0];
  assign count_eff = (radius_count > rpxy_pkg::COUNT_RESET) ? rpxy_pkg::COUNT_RESET
                                                            : radius_count;
  assign ri_outside = (ri >= count_eff);
  // Interpolate only when the next sample is in use and the fraction is nonzero.
  assign use_next   = (({1'b0, ri} + 1'b1) < {1'b0, count_eff}) && (frac != '0);

  rpxy_ram #(
    .WIDTH(rpxy_pkg::SAMPLE_BITS),
    .DEPTH(rpxy_pkg::MAX_RADIUS)
  ) u_samples (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sample_index),
    .wdata(sample_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rpxy_radius u_radius (
    .clk    (clk),
    .ctl    (radius_ctl),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .root   (root)
  );

  rpxy_interp u_interp (
    .clk   (clk),
    .ctl   (interp_ctl),
    .sample(ram_rdata),
    .frac  (frac),
    .value (interp_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpxy_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      result_valid <= 1'b0;
      radius_count <= rpxy_pkg::COUNT_RESET;
    end else begin
      cnt          <= cnt_next;
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        radius_count <= cfg_data;
      end
    end
  end

  // Result payload: hold until the next result replaces it.
  always_ff @(posedge clk) begin
    if (result_valid_next) begin
      pixel_value <= pixel_value_next;
      outside     <= outside_next;
    end
  end

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    result_valid_next = 1'b0;
    pixel_value_next  = '0;
    outside_next      = 1'b0;
    radius_ctl        = '0;
    interp_ctl        = '0;
    ram_re            = 1'b0;
    ram_raddr         = ri[rpxy_pkg::ADDR_BITS-1:0];

    case (state)
      rpxy_pkg::ST_IDLE: begin
        // Latch the coordinates on a query transfer and start squaring.
        if (accept && (cmd == rpxy_pkg::CMD_QUERY)) begin
          radius_ctl.load = 1'b1;
          cnt_next        = '0;
          state_next      = rpxy_pkg::ST_SQUARE;
        end
      end

      rpxy_pkg::ST_SQUARE: begin
        radius_ctl.sq_step = 1'b1;
        cnt_next           = cnt + 1'b1;
        if (cnt == rpxy_pkg::STEP_BITS'(rpxy_pkg::SQ_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = rpxy_pkg::ST_ROOT;
        end
      end

      rpxy_pkg::ST_ROOT: begin
        radius_ctl.rt_step = 1'b1;
        cnt_next           = cnt + 1'b1;
        if (cnt == rpxy_pkg::STEP_BITS'(rpxy_pkg::ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = rpxy_pkg::ST_CHECK;
        end
      end

      rpxy_pkg::ST_CHECK: begin
        // Answer zero with the flag when the index is past the profile,
        // else fetch the lower sample.
        if (ri_outside) begin
          result_valid_next = 1'b1;
          outside_next      = 1'b1;
          state_next        = rpxy_pkg::ST_IDLE;
        end else begin
          ram_re     = 1'b1;
          state_next = rpxy_pkg::ST_READ0;
        end
      end

      rpxy_pkg::ST_READ0: begin
        // Lower sample is on the read port now.
        if (use_next) begin
          interp_ctl.load_base = 1'b1;
          ram_re               = 1'b1;
          ram_raddr            = rpxy_pkg::ADDR_BITS'(ri + 1'b1);
          state_next           = rpxy_pkg::ST_READ1;
        end else begin
          result_valid_next = 1'b1;
          pixel_value_next  = ram_rdata;
          state_next        = rpxy_pkg::ST_IDLE;
        end
      end

      rpxy_pkg::ST_READ1: begin
        interp_ctl.load_diff = 1'b1;
        cnt_next             = '0;
        state_next           = rpxy_pkg::ST_MUL;
      end

      rpxy_pkg::ST_MUL: begin
        interp_ctl.step = 1'b1;
        cnt_next        = cnt + 1'b1;
        if (cnt == rpxy_pkg::STEP_BITS'(rpxy_pkg::MUL_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = rpxy_pkg::ST_DONE;
        end
      end

      rpxy_pkg::ST_DONE: begin
        result_valid_next = 1'b1;
        pixel_value_next  = interp_value;
        state_next        = rpxy_pkg::ST_IDLE;
      end

      default: begin
        state_next = rpxy_pkg::ST_IDLE;
      end
    endcase
  end

  // A query keeps the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == rpxy_pkg::CMD_QUERY)) |=> busy)
    else $error("query transfer did not raise busy");

  // A write transfer never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd == rpxy_pkg::CMD_WRITE)) |=> !result_valid)
    else $error("write transfer produced a result");

  // One strobe per query: never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // An outside result carries a zero value.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && outside) |-> (pixel_value == '0))
    else $error("outside result with nonzero value");

  // The store is read only while a query is in progress.
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> busy)
    else $error("sample store read while idle");

endmodule

### verif/radial_profile_to_xy_checker.sv
// Result checker for radial_profile_to_xy_core: mirrors the sample store and
// radius_count, predicts every query result and compares it at the strobe.
// Depends on rpxy_pkg only; watches the block's ports, never its internals.
module radial_profile_to_xy_checker
  import rpxy_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          cmd,
  input  logic        [7:0]             sample_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic        [COORD_BITS-1:0]  pixel_x,
  input  logic        [COORD_BITS-1:0]  pixel_y,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic        [COUNT_BITS-1:0]  cfg_data,
  input  logic                          result_valid,
  input  logic signed [SAMPLE_BITS-1:0] pixel_value,
  input  logic                          outside,
  output int                            pending,
  output int                            mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          outside;
    logic [COORD_BITS-1:0]         px;
    logic [COORD_BITS-1:0]         py;
  } pixel_result_t;

  logic signed [SAMPLE_BITS-1:0] radial_store [MAX_RADIUS];
  logic [COUNT_BITS-1:0]         profile_len;
  pixel_result_t                 pixel_q [$];

  initial begin
    pending    = 0;
    mismatches = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("[%0t ns] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Largest r with r*r <= n, built one bit at a time from the top.
  function automatic logic [20:0] radius_root(input logic [63:0] n);
    logic [20:0] r;
    logic [20:0] trial;
    r = '0;
    for (int b = 20; b >= 0; b--) begin
      trial = r | (21'd1 << b);
      if (64'(trial) * 64'(trial) <= n) r = trial;
    end
    return r;
  endfunction

  function automatic pixel_result_t predict_pixel(input logic [COORD_BITS-1:0] x,
                                                  input logic [COORD_BITS-1:0] y);
    logic [63:0]    sumsq;
    logic [20:0]    root;
    int unsigned    ring;
    logic [FRAC_BITS-1:0] frac;
    int unsigned    span;
    longint         lo;
    longint         hi;
    longint         v;
    pixel_result_t  res;
    sumsq = (64'(x) * 64'(x) + 64'(y) * 64'(y)) << (2 * FRAC_BITS);
    root  = radius_root(sumsq);
    ring  = int'(root >> FRAC_BITS);
    frac  = root[FRAC_BITS-1:0];
    span  = (profile_len > MAX_RADIUS) ? MAX_RADIUS : int'(profile_len);
    res.px = x;
    res.py = y;
    if (ring >= span) begin
      res.value   = '0;
      res.outside = 1'b1;
    end else begin
      lo = radial_store[ring];
      if (ring + 1 >= span || frac == '0) begin
        v = lo;
      end else begin
        hi = radial_store[ring + 1];
        // arithmetic shift of a signed product floors toward minus infinity
        v = lo + ((longint'(frac) * (hi - lo)) >>> FRAC_BITS);
      end
      res.value   = v[SAMPLE_BITS-1:0];
      res.outside = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    pixel_result_t want;
    if (rst) begin
      profile_len = COUNT_RESET;
      pixel_q.delete();
    end else begin
      // compare first: a new command may be taken on the strobe cycle
      if (result_valid === 1'b1) begin
        if (pixel_q.size() == 0) begin
          flag_mismatch($sformatf("result with no query waiting (value %0d, outside %b)",
                                  pixel_value, outside));
        end else begin
          want = pixel_q.pop_front();
          if (pixel_value !== want.value)
            flag_mismatch($sformatf("pixel (%0d,%0d) pixel_value %0d, expected %0d",
                                    want.px, want.py, pixel_value, want.value));
          if (outside !== want.outside)
            flag_mismatch($sformatf("pixel (%0d,%0d) outside %b, expected %b",
                                    want.px, want.py, outside, want.outside));
        end
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) profile_len = cfg_data;
      if (start === 1'b1 && busy === 1'b0) begin
        if (cmd == CMD_WRITE) begin
          if (int'(sample_index) < MAX_RADIUS) radial_store[sample_index] = sample_value;
        end else begin
          pixel_q.push_back(predict_pixel(pixel_x, pixel_y));
        end
      end
    end
    pending <= pixel_q.size();
  end

endmodule

### verif/testbench.sv
// Top of the radial_profile_to_xy_core testbench: clock, reset, command and
// configuration stimulus, and the final verdict. Depends on rpxy_pkg, the
// core and radial_profile_to_xy_checker, which does all predicting and comparing.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rpxy_pkg::*;

  localparam int ITEM_GOAL    = 1550;
  localparam int MAX_GAP      = 17;
  // room for the tail beyond the longest query
  localparam int DRAIN_CYCLES = 60;
  // margin after the block is idle, to cover a trailing write
  localparam int SETTLE_CYCLES = 4;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          clk          = 1'b0;
  logic                          rst          = 1'b1;
  logic                          start        = 1'b0;
  logic                          busy;
  logic                          cmd          = CMD_WRITE;
  logic        [7:0]             sample_index = '0;
  logic signed [SAMPLE_BITS-1:0] sample_value = '0;
  logic        [COORD_BITS-1:0]  pixel_x      = '0;
  logic        [COORD_BITS-1:0]  pixel_y      = '0;
  logic                          cfg_valid    = 1'b0;
  logic                          cfg_ready;
  logic        [COUNT_BITS-1:0]  cfg_data     = '0;
  logic                          result_valid;
  logic signed [SAMPLE_BITS-1:0] pixel_value;
  logic                          outside;

  int pending_results;
  int mismatch_count;

  // Stimulus bookkeeping: entries of the store that hold a written sample,
  // the last sample drawn (for smooth profiles) and the idle burst state.
  int                            sent_items = 0;
  int                            burst_left = 0;
  bit                            loaded_map [MAX_RADIUS];
  logic signed [SAMPLE_BITS-1:0] last_sample = '0;

  always #4 clk = ~clk;

  radial_profile_to_xy_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .pixel_value  (pixel_value),
    .outside      (outside)
  );

  radial_profile_to_xy_checker profile_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .sample_index (sample_index),
    .sample_value (sample_value),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .pixel_value  (pixel_value),
    .outside      (outside),
    .pending      (pending_results),
    .mismatches   (mismatch_count)
  );

  // Draw a sample: half the time full-range noise, sometimes an extreme, sometimes a
  // small step from the previous one so neighbors differ only a little.
  function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
    logic signed [SAMPLE_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = SAMPLE_MAX;
      end
      1: begin
        v = SAMPLE_MIN;
      end
      2, 3, 4: begin
        v = last_sample + SAMPLE_BITS'($urandom_range(0, 8191)) - SAMPLE_BITS'(4096);
      end
      default: begin
        v = SAMPLE_BITS'($urandom);
      end
    endcase
    last_sample = v;
    return v;
  endfunction

  // Present one command and hold it until the edge that takes it.
  // Idle first for a drawn number of cycles, except inside a burst where
  // commands follow back to back; start is only lowered when a gap is drawn,
  // so it never gets two assignments in one step.
  task automatic transfer_item(input logic op, input logic [7:0] idx,
                               input logic signed [SAMPLE_BITS-1:0] val,
                               input logic [COORD_BITS-1:0] px,
                               input logic [COORD_BITS-1:0] py);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= op;
    sample_index <= idx;
    sample_value <= val;
    pixel_x      <= px;
    pixel_y      <= py;
    // busy read here is its value before this edge, so the test is exact
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sent_items++;
  endtask

  // Unused fields of every command carry noise so they toggle too.
  task automatic write_sample(input logic [7:0] idx, input logic signed [SAMPLE_BITS-1:0] val);
    transfer_item(CMD_WRITE, idx, val, COORD_BITS'($urandom), COORD_BITS'($urandom));
    loaded_map[idx] = 1'b1;
  endtask

  task automatic query_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
    transfer_item(CMD_QUERY, 8'($urandom), SAMPLE_BITS'($urandom), px, py);
  endtask

  // Drop start and wait until every query has answered and the block is idle,
  // then a few more cycles in case the last command was a write.
  // The first edge lets the checker's pending count catch up with a transfer
  // taken at this very edge.
  task automatic settle_block();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write radius_count; only called with the block idle.
  task automatic set_profile_len(input logic [COUNT_BITS-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= COUNT_BITS'($urandom);
  endtask

  // Make sure every entry below span holds a sample, then rewrite a few.
  task automatic load_profile(input int span);
    for (int i = 0; i < span; i++)
      if (!loaded_map[i]) write_sample(8'(i), next_sample());
    repeat ($urandom_range(0, 24)) write_sample(8'($urandom_range(0, 255)), next_sample());
  endtask

  initial begin : stimulus
    logic [COUNT_BITS-1:0] len;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    int                    span;
    int                    lim;
    int                    phase;
    int                    a;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, radius_count still at its reset value of 256.
    // Samples: zero, max, min, minus one, max, and a plain value, so the
    // interpolations below swing across the full range both ways.
    write_sample(8'd0, '0);
    write_sample(8'd1, SAMPLE_MAX);
    write_sample(8'd2, SAMPLE_MIN);
    write_sample(8'd3, '1);
    write_sample(8'd4, SAMPLE_MAX);
    write_sample(8'd5, SAMPLE_BITS'(24'h123456));
    query_pixel(8'd0, 8'd0);       // zero radius: sample 0 as stored
    query_pixel(8'd1, 8'd1);       // max down to min, floor on a negative product
    query_pixel(8'd1, 8'd2);       // min up to minus one
    query_pixel(8'd2, 8'd2);
    query_pixel(8'd2, 8'd3);       // minus one up to max
    query_pixel(8'd3, 8'd3);       // max down to a plain value
    query_pixel(8'd0, 8'd1);       // exact radius on an axis
    query_pixel(8'd4, 8'd3);       // exact radius off the axes
    query_pixel(8'd255, 8'd255);   // far corner, beyond the profile

    // A single sample: the last sample is returned as is, the next ring is outside.
    settle_block();
    set_profile_len(9'd1);
    query_pixel(8'd0, 8'd0);
    query_pixel(8'd0, 8'd1);

    // No samples in use: everything is outside.
    settle_block();
    set_profile_len(9'd0);
    query_pixel(8'd0, 8'd0);

    // Three samples: interpolate inside, last sample with and without a
    // fraction, and a radius landing exactly on the end.
    settle_block();
    set_profile_len(9'd3);
    query_pixel(8'd1, 8'd1);
    query_pixel(8'd2, 8'd0);
    query_pixel(8'd1, 8'd2);
    query_pixel(8'd3, 8'd0);

    // Random part: one profile row per phase. Set the count, load the row,
    // then query pixels, mostly inside the row, with some stray writes.
    // The first phases pin the count to its extremes, including values above
    // the store size, which act as a full store.
    phase = 0;
    while (sent_items < ITEM_GOAL) begin
      case (phase)
        0: len = 9'd256;
        1: len = 9'd511;
        2: len = 9'd1;
        3: len = 9'd0;
        4: len = 9'd2;
        default: begin
          case ($urandom_range(0, 7))
            0:       len = 9'd1;
            1:       len = 9'd256;
            2:       len = COUNT_BITS'($urandom_range(257, 511));
            3:       len = 9'd2;
            default: len = COUNT_BITS'($urandom_range(3, 255));
          endcase
        end
      endcase
      settle_block();
      set_profile_len(len);
      span = (len > MAX_RADIUS) ? MAX_RADIUS : int'(len);
      load_profile(span);
      lim = (span > 255) ? 255 : span;
      repeat ($urandom_range(60, 130)) begin
        case ($urandom_range(0, 9))
          0: begin
            write_sample(8'($urandom_range(0, 255)), next_sample());
          end
          1, 2: begin
            query_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom));
          end
          3: begin
            // on an axis the radius is a whole number: no interpolation
            a = $urandom_range(0, lim);
            if ($urandom_range(0, 1) == 0) query_pixel(COORD_BITS'(a), '0);
            else query_pixel('0, COORD_BITS'(a));
          end
          default: begin
            x = COORD_BITS'($urandom_range(0, lim));
            y = COORD_BITS'($urandom_range(0, lim));
            query_pixel(x, y);
          end
        endcase
      end
      phase++;
    end

    // Drain: wait for the last answers, then give stray strobes a chance.
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard: a correct run needs well under a fifth of this.
  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results still expected", pending_results);
    $display("== FAIL ==");
    $finish;
  end

endmodule
